// File: rtl/core/fsnr_pkg.sv
// shared types and constants of the frame snr accumulator
`default_nettype none
package fsnr_pkg;

  localparam int unsigned DEF_MAX_FRAME   = 4096;
  localparam int unsigned DEF_SAMPLE_BITS = 16;
  localparam int unsigned DEF_FIFO_DEPTH  = 2;

  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned LEN_CFG_W   = 13;
  localparam int unsigned SIL_W       = 30;
  localparam int unsigned DB_W        = 16;
  localparam int unsigned TOT_W       = 64;
  localparam int unsigned WIDE_W      = 128;
  localparam int unsigned LOG_W       = 23;

  localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_SILENCE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LENGTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SILENCE_LEVEL = 2'd2;

  localparam logic [LEN_CFG_W-1:0] RST_FRAME_LENGTH  = 13'd512;
  localparam logic [SIL_W-1:0]     RST_SILENCE_LEVEL = 30'd1074;

  // 10*log10(2) in q16
  localparam logic [31:0] DB_PER_LOG2_Q16 = 32'd197283;
  localparam logic [DB_W-1:0] DB_MAX = 16'h7fff;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_THR,
    ST_ACC,
    ST_SNR0,
    ST_SNR1,
    ST_SNR2,
    ST_CORR0,
    ST_PPM,
    ST_PPA,
    ST_CMP,
    ST_CORR1,
    ST_CORR2,
    ST_DBM,
    ST_DBR,
    ST_LNORM,
    ST_LSQM,
    ST_LSQU,
    ST_DONE
  } back_state_e;

endpackage
`default_nettype wire

// File: rtl/core/fsnr_fifo.sv
// short queue of finished frame sums between front and back
`default_nettype none
module fsnr_fifo
  import fsnr_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = DEF_FIFO_DEPTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire logic [WIDTH-1:0]             wdata_i,
  input  wire logic                         pop_i,
  output logic [WIDTH-1:0]                  rdata_o,
  output logic                              empty_o,
  output logic [$clog2(DEPTH+1)-1:0]        count_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign do_push = push_i && (cnt_q != CNT_W'(DEPTH));
  assign do_pop  = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign rdata_o = mem_q[rptr_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule
`default_nettype wire

// File: rtl/core/fsnr_front.sv
// sample intake: products, frame sums and frame end detection
`default_nettype none
module fsnr_front
  import fsnr_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int unsigned MAX_FRAME   = DEF_MAX_FRAME,
  parameter int unsigned FIFO_DEPTH  = DEF_FIFO_DEPTH,
  parameter int unsigned IDX_W       = $clog2(MAX_FRAME+1),
  parameter int unsigned EN_W        = 2*SAMPLE_BITS-1+$clog2(MAX_FRAME),
  parameter int unsigned CR_W        = 2*SAMPLE_BITS+$clog2(MAX_FRAME),
  parameter int unsigned DF_W        = 2*SAMPLE_BITS+1+$clog2(MAX_FRAME),
  parameter int unsigned REC_W       = 2*EN_W+CR_W+DF_W+1
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push_i,
  output logic                                 full_o,
  input  wire logic signed [SAMPLE_BITS-1:0]   signal_sample_i,
  input  wire logic signed [SAMPLE_BITS-1:0]   reference_sample_i,
  input  wire logic                            clear_totals_i,
  input  wire logic [IDX_W-1:0]                frame_len_i,
  input  wire logic [$clog2(FIFO_DEPTH+1)-1:0] fifo_count_i,
  output logic                                 rec_push_o,
  output logic [REC_W-1:0]                     rec_data_o
);

  localparam int unsigned PW = 2*SAMPLE_BITS;

  logic                        acc_in;
  logic [IDX_W-1:0]            idx_q, idx_nxt;
  logic                        last;
  logic signed [SAMPLE_BITS:0] diff;
  logic signed [PW-1:0]        ss, rr, sr;
  logic signed [PW+1:0]        dd;

  logic                        s1_valid_q, s1_last_q, s1_clr_q;
  logic [PW-2:0]               ss_q, rr_q;
  logic signed [PW-1:0]        sr_q;
  logic [PW:0]                 dd_q;

  logic [EN_W-1:0]             fse_q, fre_q, fse_n, fre_n;
  logic [CR_W-1:0]             fcs_q, fcs_n;
  logic [DF_W-1:0]             fde_q, fde_n;

  assign full_o = (32'(fifo_count_i) + 32'(s1_valid_q && s1_last_q)) >= FIFO_DEPTH;
  assign acc_in = push_i && !full_o;

  assign idx_nxt = idx_q + 1'b1;
  assign last    = (idx_nxt >= frame_len_i);
  assign diff    = (SAMPLE_BITS+1)'(signal_sample_i) - (SAMPLE_BITS+1)'(reference_sample_i);
  assign ss      = signal_sample_i * signal_sample_i;
  assign rr      = reference_sample_i * reference_sample_i;
  assign sr      = signal_sample_i * reference_sample_i;
  assign dd      = diff * diff;

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      ss_q     <= ss[PW-2:0];
      rr_q     <= rr[PW-2:0];
      sr_q     <= sr;
      dd_q     <= dd[PW:0];
      s1_clr_q <= clear_totals_i;
    end
  end

  assign fse_n = fse_q + EN_W'(ss_q);
  assign fre_n = fre_q + EN_W'(rr_q);
  assign fcs_n = fcs_q + {{(CR_W-PW){sr_q[PW-1]}}, sr_q};
  assign fde_n = fde_q + DF_W'(dd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
      fse_q      <= '0;
      fre_q      <= '0;
      fcs_q      <= '0;
      fde_q      <= '0;
    end else begin
      s1_valid_q <= acc_in;
      if (acc_in) begin
        s1_last_q <= last;
        idx_q     <= last ? '0 : idx_nxt;
      end
      if (s1_valid_q) begin
        if (s1_last_q) begin
          fse_q <= '0;
          fre_q <= '0;
          fcs_q <= '0;
          fde_q <= '0;
        end else begin
          fse_q <= fse_n;
          fre_q <= fre_n;
          fcs_q <= fcs_n;
          fde_q <= fde_n;
        end
      end
    end
  end

  assign rec_push_o = s1_valid_q && s1_last_q;
  assign rec_data_o = {fse_n, fre_n, fcs_n, fde_n, s1_clr_q};

endmodule
`default_nettype wire

// File: rtl/core/fsnr_back.sv
// frame completion: saturating totals, log2 unit and db conversion
`default_nettype none
module fsnr_back
  import fsnr_pkg::*;
#(
  parameter int unsigned IDX_W = 13,
  parameter int unsigned EN_W  = 43,
  parameter int unsigned CR_W  = 44,
  parameter int unsigned DF_W  = 45,
  parameter int unsigned REC_W = 2*EN_W+CR_W+DF_W+1
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    rec_empty_i,
  input  wire logic [REC_W-1:0]        rec_data_i,
  output logic                         rec_pop_o,
  input  wire logic                    check_silence_i,
  input  wire logic [SIL_W-1:0]        silence_level_i,
  input  wire logic [IDX_W-1:0]        frame_len_i,
  output logic                         empty_o,
  input  wire logic                    pop_i,
  output logic signed [DB_W-1:0]       snr_db_o,
  output logic signed [DB_W-1:0]       correlation_snr_db_o,
  output logic                         frame_skipped_o
);

  back_state_e state_q, state_d, ret_q;

  logic [EN_W-1:0]   fse_q, fre_q;
  logic [CR_W-1:0]   fcs_q;
  logic [DF_W-1:0]   fde_q;
  logic              clr_q, skip_q, db_corr_q;
  logic [TOT_W-1:0]  ts_q, tr_q, td_q, tc_q, pm;
  logic [TOT_W:0]    ts_sum, tr_sum, td_sum, tc_sum;
  logic              skip_now;

  logic [31:0]       mul_a, mul_b;
  logic [63:0]       prod_q;

  logic [2:0]        pp_idx_q;
  logic [WIDE_W-1:0] pp_sh, acc_q, acc_n, n_q, p_q;

  logic [WIDE_W-1:0] x_q;
  logic [6:0]        cnt_q;
  logic [31:0]       m_q;
  logic [15:0]       frac_q;
  logic [3:0]        rnd_q;
  logic [LOG_W-1:0]  lres, la_q;
  logic [LOG_W:0]    delta;
  logic [LOG_W-1:0]  mag_q;
  logic              neg_q;
  logic [39:0]       rdb;
  logic [63:0]       rsum;
  logic [DB_W-1:0]   db_val;
  logic [DB_W-1:0]   snr_q, corr_q;

  logic              out_valid_q;
  logic              out_take;
  logic [DB_W-1:0]   out_snr_q, out_corr_q;
  logic              out_skip_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (!rec_empty_i) state_d = ST_THR;
      ST_THR:   state_d = ST_ACC;
      ST_ACC:   state_d = ST_SNR0;
      ST_SNR0:  state_d = ((ts_q != '0) && (td_q != '0)) ? ST_LNORM : ST_CORR0;
      ST_SNR1:  state_d = ST_LNORM;
      ST_SNR2:  state_d = ST_DBM;
      ST_CORR0: state_d = ((ts_q != '0) && (tr_q != '0)) ? ST_PPM : ST_DONE;
      ST_PPM:   state_d = ST_PPA;
      ST_PPA:   state_d = (pp_idx_q == 3'd7) ? ST_CMP : ST_PPM;
      ST_CMP:   state_d = (p_q >= n_q) ? ST_DONE : ST_LNORM;
      ST_CORR1: state_d = ST_LNORM;
      ST_CORR2: state_d = ST_DBM;
      ST_DBM:   state_d = ST_DBR;
      ST_DBR:   state_d = db_corr_q ? ST_DONE : ST_CORR0;
      ST_LNORM: if (x_q[WIDE_W-1]) state_d = ST_LSQM;
      ST_LSQM:  state_d = ST_LSQU;
      ST_LSQU:  state_d = (rnd_q == 4'd15) ? ret_q : ST_LSQM;
      ST_DONE:  if (!out_valid_q || pop_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    rec_pop_o = 1'b0;
    unique case (state_q)
      ST_IDLE: rec_pop_o = !rec_empty_i;
      ST_THR: begin
        mul_a = 32'(silence_level_i);
        mul_b = 32'(frame_len_i);
      end
      ST_PPM: begin
        if (!pp_idx_q[2]) begin
          mul_a = pp_idx_q[1] ? ts_q[63:32] : ts_q[31:0];
          mul_b = pp_idx_q[0] ? tr_q[63:32] : tr_q[31:0];
        end else begin
          mul_a = pp_idx_q[1] ? pm[63:32] : pm[31:0];
          mul_b = pp_idx_q[0] ? pm[63:32] : pm[31:0];
        end
      end
      ST_LSQM: begin
        mul_a = m_q;
        mul_b = m_q;
      end
      ST_DBM: begin
        mul_a = 32'(mag_q);
        mul_b = DB_PER_LOG2_Q16;
      end
      default: ;
    endcase
  end

  assign skip_now = check_silence_i && (TOT_W'(fre_q) < prod_q);
  assign ts_sum   = {1'b0, ts_q} + (TOT_W+1)'(fse_q);
  assign tr_sum   = {1'b0, tr_q} + (TOT_W+1)'(fre_q);
  assign td_sum   = {1'b0, td_q} + (TOT_W+1)'(fde_q);
  assign tc_sum   = {tc_q[TOT_W-1], tc_q} + {{(TOT_W+1-CR_W){fcs_q[CR_W-1]}}, fcs_q};
  assign pm       = tc_q[TOT_W-1] ? (~tc_q + 1'b1) : tc_q;

  always_comb begin
    case (pp_idx_q[1:0])
      2'd0:    pp_sh = WIDE_W'(prod_q);
      2'd3:    pp_sh = WIDE_W'(prod_q) << 64;
      default: pp_sh = WIDE_W'(prod_q) << 32;
    endcase
  end
  assign acc_n = acc_q + pp_sh;

  assign lres  = {7'(7'd127 - cnt_q), frac_q};
  assign delta = {1'b0, la_q} - {1'b0, lres};

  assign rsum = prod_q + 64'h80_0000;
  assign rdb  = rsum[63:24];
  always_comb begin
    if (neg_q) begin
      db_val = (rdb > 40'd32768) ? 16'h8000 : 16'(~rdb + 1'b1);
    end else begin
      db_val = (rdb > 40'd32767) ? DB_MAX : rdb[DB_W-1:0];
    end
  end

  assign out_take = (state_q == ST_DONE) && (!out_valid_q || pop_i);

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      ST_IDLE: begin
        {fse_q, fre_q, fcs_q, fde_q, clr_q} <= rec_data_i;
        db_corr_q <= 1'b0;
        snr_q     <= '0;
        corr_q    <= '0;
      end
      ST_ACC:  skip_q <= skip_now;
      ST_SNR0: begin
        x_q   <= WIDE_W'(ts_q);
        cnt_q <= '0;
        ret_q <= ST_SNR1;
      end
      ST_SNR1: begin
        la_q  <= lres;
        x_q   <= WIDE_W'(td_q);
        cnt_q <= '0;
        ret_q <= ST_SNR2;
      end
      ST_SNR2, ST_CORR2: begin
        neg_q <= delta[LOG_W];
        mag_q <= delta[LOG_W] ? LOG_W'(~delta + 1'b1) : delta[LOG_W-1:0];
      end
      ST_CORR0: begin
        pp_idx_q  <= '0;
        acc_q     <= '0;
        db_corr_q <= 1'b1;
      end
      ST_PPA: begin
        pp_idx_q <= pp_idx_q + 1'b1;
        if (pp_idx_q == 3'd3) begin
          n_q   <= acc_n;
          acc_q <= '0;
        end else if (pp_idx_q == 3'd7) begin
          p_q <= acc_n;
        end else begin
          acc_q <= acc_n;
        end
      end
      ST_CMP: begin
        if (p_q >= n_q) corr_q <= DB_MAX;
        x_q   <= n_q;
        cnt_q <= '0;
        ret_q <= ST_CORR1;
      end
      ST_CORR1: begin
        la_q  <= lres;
        x_q   <= n_q - p_q;
        cnt_q <= '0;
        ret_q <= ST_CORR2;
      end
      ST_DBR: begin
        if (db_corr_q) corr_q <= db_val;
        else snr_q <= db_val;
      end
      ST_LNORM: begin
        if (x_q[WIDE_W-1:WIDE_W-16] == '0) begin
          x_q   <= x_q << 16;
          cnt_q <= cnt_q + 7'd16;
        end else if (!x_q[WIDE_W-1]) begin
          x_q   <= x_q << 1;
          cnt_q <= cnt_q + 7'd1;
        end else begin
          m_q    <= x_q[WIDE_W-1:WIDE_W-32];
          frac_q <= '0;
          rnd_q  <= '0;
        end
      end
      ST_LSQU: begin
        rnd_q <= rnd_q + 1'b1;
        if (prod_q[63]) begin
          frac_q <= {frac_q[14:0], 1'b1};
          m_q    <= prod_q[63:32];
        end else begin
          frac_q <= {frac_q[14:0], 1'b0};
          m_q    <= prod_q[62:31];
        end
      end
      default: ;
    endcase
    if (out_take) begin
      out_snr_q  <= snr_q;
      out_corr_q <= corr_q;
      out_skip_q <= skip_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      ts_q        <= '0;
      tr_q        <= '0;
      td_q        <= '0;
      tc_q        <= '0;
    end else begin
      state_q <= state_d;
      if (out_take) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_ACC && !skip_now) begin
        ts_q <= ts_sum[TOT_W] ? '1 : ts_sum[TOT_W-1:0];
        tr_q <= tr_sum[TOT_W] ? '1 : tr_sum[TOT_W-1:0];
        td_q <= td_sum[TOT_W] ? '1 : td_sum[TOT_W-1:0];
        if (tc_sum[TOT_W] != tc_sum[TOT_W-1]) begin
          tc_q <= {tc_sum[TOT_W], {(TOT_W-1){~tc_sum[TOT_W]}}};
        end else begin
          tc_q <= tc_sum[TOT_W-1:0];
        end
      end
      if (out_take && clr_q) begin
        ts_q <= '0;
        tr_q <= '0;
        td_q <= '0;
        tc_q <= '0;
      end
    end
  end

  assign empty_o              = !out_valid_q;
  assign snr_db_o             = out_snr_q;
  assign correlation_snr_db_o = out_corr_q;
  assign frame_skipped_o      = out_skip_q;

endmodule
`default_nettype wire

// File: rtl/core/frame_snr_accumulator_db_top.sv
// top level of the frame snr accumulator
// The front takes one sample pair per clock while full_o is low and keeps the frame
// sums; at each frame end the sums go into a two-entry queue. The back then updates the
// saturating totals and forms both dB values through one shared 32x32 multiplier:
// 128-bit products in eight partial steps, four log2 evaluations (a normalizing shift
// plus 16 squaring rounds each) and two scaling steps. Frames longer than the work of
// the back stream at one sample per cycle; shorter frames make push see full while the
// queue waits for the back.
`default_nettype none
module frame_snr_accumulator_db_top
  import fsnr_pkg::*;
#(
  parameter int unsigned MAX_FRAME   = DEF_MAX_FRAME,
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  output logic                               full_o,
  input  wire logic signed [SAMPLE_BITS-1:0] signal_sample_i,
  input  wire logic signed [SAMPLE_BITS-1:0] reference_sample_i,
  input  wire logic                          clear_totals_i,
  output logic                               empty_o,
  input  wire logic                          pop_i,
  output logic signed [DB_W-1:0]             snr_db_o,
  output logic signed [DB_W-1:0]             correlation_snr_db_o,
  output logic                               frame_skipped_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [CFG_INDEX_W-1:0]        cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(MAX_FRAME+1);
  localparam int unsigned EN_W  = 2*SAMPLE_BITS-1+$clog2(MAX_FRAME);
  localparam int unsigned CR_W  = 2*SAMPLE_BITS+$clog2(MAX_FRAME);
  localparam int unsigned DF_W  = 2*SAMPLE_BITS+1+$clog2(MAX_FRAME);
  localparam int unsigned REC_W = 2*EN_W+CR_W+DF_W+1;
  localparam int unsigned CNT_W = $clog2(DEF_FIFO_DEPTH+1);

  logic                 check_silence_q;
  logic [LEN_CFG_W-1:0] frame_length_q;
  logic [SIL_W-1:0]     silence_level_q;
  logic [IDX_W-1:0]     frame_len;

  logic                 rec_push, rec_pop, rec_empty;
  logic [REC_W-1:0]     rec_wdata, rec_rdata;
  logic [CNT_W-1:0]     rec_count;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_silence_q <= 1'b0;
      frame_length_q  <= RST_FRAME_LENGTH;
      silence_level_q <= RST_SILENCE_LEVEL;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CHECK_SILENCE: check_silence_q <= cfg_data_i[0];
        CFG_FRAME_LENGTH:  frame_length_q  <= cfg_data_i[LEN_CFG_W-1:0];
        CFG_SILENCE_LEVEL: silence_level_q <= cfg_data_i[SIL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_length_q == '0) begin
      frame_len = IDX_W'(1);
    end else if (32'(frame_length_q) > MAX_FRAME) begin
      frame_len = IDX_W'(MAX_FRAME);
    end else begin
      frame_len = IDX_W'(frame_length_q);
    end
  end

  fsnr_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_FRAME   (MAX_FRAME),
    .FIFO_DEPTH  (DEF_FIFO_DEPTH),
    .IDX_W       (IDX_W),
    .EN_W        (EN_W),
    .CR_W        (CR_W),
    .DF_W        (DF_W),
    .REC_W       (REC_W)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push_i             (push_i),
    .full_o             (full_o),
    .signal_sample_i    (signal_sample_i),
    .reference_sample_i (reference_sample_i),
    .clear_totals_i     (clear_totals_i),
    .frame_len_i        (frame_len),
    .fifo_count_i       (rec_count),
    .rec_push_o         (rec_push),
    .rec_data_o         (rec_wdata)
  );

  fsnr_fifo #(
    .WIDTH (REC_W),
    .DEPTH (DEF_FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .wdata_i (rec_wdata),
    .pop_i   (rec_pop),
    .rdata_o (rec_rdata),
    .empty_o (rec_empty),
    .count_o (rec_count)
  );

  fsnr_back #(
    .IDX_W (IDX_W),
    .EN_W  (EN_W),
    .CR_W  (CR_W),
    .DF_W  (DF_W),
    .REC_W (REC_W)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .rec_empty_i          (rec_empty),
    .rec_data_i           (rec_rdata),
    .rec_pop_o            (rec_pop),
    .check_silence_i      (check_silence_q),
    .silence_level_i      (silence_level_q),
    .frame_len_i          (frame_len),
    .empty_o              (empty_o),
    .pop_i                (pop_i),
    .snr_db_o             (snr_db_o),
    .correlation_snr_db_o (correlation_snr_db_o),
    .frame_skipped_o      (frame_skipped_o)
  );

endmodule
`default_nettype wire
